// ----- rtl/ostc_pkg.sv -----
// Package with the types, sizes and codes of the order-statistic count tree.
`timescale 1ns / 1ps

package ostc_pkg;

  localparam int LEAF_BITS  = 16;
  localparam int COUNT_BITS = 32;
  localparam int KEY_W      = 17;
  localparam int DELTA_W    = 32;
  localparam int RANK_W     = 32;
  localparam int STATUS_W   = 2;

  localparam int NODE_W = LEAF_BITS + 1;
  localparam int DEPTH  = 2 ** NODE_W;
  localparam int ALU_W  = ((COUNT_BITS > DELTA_W) ? COUNT_BITS : DELTA_W) + 1;
  localparam int KCMP_W = (KEY_W > NODE_W) ? KEY_W : NODE_W;

  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ALU_W-1:0]      alu_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [STATUS_W-1:0]   status_t;

  localparam node_t ROOT_NODE = node_t'(1);
  localparam logic [KCMP_W-1:0] NUM_LEAVES = KCMP_W'(1) << LEAF_BITS;

  localparam logic FN_ADD = 1'b0;
  localparam logic FN_SEL = 1'b1;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_ADD_REJ  = 2'd1;
  localparam status_t ST_RANK_ERR = 2'd2;

  typedef struct packed {
    logic                      func;
    logic [KEY_W-1:0]          key;
    logic signed [DELTA_W-1:0] delta;
    logic [RANK_W-1:0]         rank;
  } in_item_t;

  typedef struct packed {
    status_t status;
    key_t    found_key;
  } out_item_t;

  typedef struct packed {
    logic   we;
    node_t  waddr;
    count_t wdata;
    node_t  raddr;
  } mem_req_t;

endpackage

// ----- rtl/order_statistic_count_tree_top.sv -----
// Top level of the order-statistic count tree: sequencer, shared adder and node memory.
//
//   Channel  Ports                       Handshake
//   in       start, busy, in_item        taken when start is high and busy is low
//   out      out_valid, out_item         one-cycle strobe, always taken
//
// A select item reads the root, then walks down one level at a time and updates
// the path back up one level at a time, all bound by the single read port of
// the node memory. An add updates the path from its leaf up to the root, and a
// rejected or zero-delta item ends without a path update. After reset every node
// of the memory is cleared, one node a cycle, with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps

module order_statistic_count_tree_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ostc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ostc_pkg::out_item_t out_item
);
  import ostc_pkg::*;

  mem_req_t mem_req;
  count_t   rd_data;
  alu_t     alu_a;
  alu_t     alu_b;
  alu_t     alu_y;
  logic     alu_sub;

  ostc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_sub   (alu_sub),
    .alu_y     (alu_y),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  ostc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  ostc_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/ostc_mem.sv -----
// Node count memory with one write port and one registered read port.
`timescale 1ns / 1ps

module ostc_mem (
  input  logic              clk,
  input  ostc_pkg::mem_req_t req,
  output ostc_pkg::count_t   rd_data
);
  import ostc_pkg::*;

  count_t mem_q [DEPTH];
  count_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_q[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem_q[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ostc_alu.sv -----
// Shared adder and subtractor used for the count sums and count compares of the tree.
`timescale 1ns / 1ps

module ostc_alu (
  input  ostc_pkg::alu_t a,
  input  ostc_pkg::alu_t b,
  input  logic           sub,
  output ostc_pkg::alu_t y
);
  import ostc_pkg::*;

  always_comb begin
    if (sub == ALU_SUB) begin
      y = a - b;
    end else begin
      y = a + b;
    end
  end

endmodule

// ----- rtl/ostc_ctrl.sv -----
// Sequencer that clears the tree, walks it down for a select and updates one path up.
`timescale 1ns / 1ps

module ostc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ostc_pkg::in_item_t  in_item,
  output logic                busy,
  output ostc_pkg::mem_req_t  mem_req,
  input  ostc_pkg::count_t    rd_data,
  output ostc_pkg::alu_t      alu_a,
  output ostc_pkg::alu_t      alu_b,
  output logic                alu_sub,
  input  ostc_pkg::alu_t      alu_y,
  output logic                out_valid,
  output ostc_pkg::out_item_t out_item
);
  import ostc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_DOWN  = 3'd4;
  localparam logic [2:0] S_UP    = 3'd5;

  logic [2:0] state_r, state_nxt;
  node_t      clr_r, clr_nxt;
  in_item_t   item_r, item_nxt;
  node_t      node_r, node_nxt;
  count_t     rem_r, rem_nxt;
  key_t       found_r, found_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic [KCMP_W-1:0] key_ext;
  logic [KCMP_W-1:0] key_m1;
  logic              key_ok;
  node_t             leaf_addr;
  alu_t              dext;
  alu_t              mag;
  alu_t              raw_ext;
  alu_t              rank_ext;
  alu_t              rd_ext;
  alu_t              rem_ext;
  count_t            d_step;
  logic              neg;
  logic              go_left;
  node_t             child;
  node_t             leaf_key;

  assign key_ext   = KCMP_W'(item_r.key);
  assign key_m1    = key_ext - KCMP_W'(1);
  assign key_ok    = (key_ext != '0) && (key_ext <= NUM_LEAVES);
  assign leaf_addr = {1'b1, key_m1[LEAF_BITS-1:0]};
  assign dext      = {{(ALU_W-DELTA_W){item_r.delta[DELTA_W-1]}}, item_r.delta};
  assign mag       = '0 - dext;
  assign raw_ext   = {{(ALU_W-DELTA_W){1'b0}}, item_r.delta};
  assign rank_ext  = {{(ALU_W-RANK_W){1'b0}}, item_r.rank};
  assign rd_ext    = {{(ALU_W-COUNT_BITS){1'b0}}, rd_data};
  assign rem_ext   = {{(ALU_W-COUNT_BITS){1'b0}}, rem_r};
  assign d_step    = (item_r.func == FN_ADD) ? dext[COUNT_BITS-1:0] : '1;
  assign neg       = alu_y[ALU_W-1];
  assign go_left   = neg || (alu_y == '0);
  assign child     = {node_r[NODE_W-2:0], ~go_left};
  assign leaf_key  = {1'b0, child[LEAF_BITS-1:0]} + NODE_W'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    node_nxt      = node_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = node_r;
    mem_req.wdata = alu_y[COUNT_BITS-1:0];
    mem_req.raddr = ROOT_NODE;
    alu_a         = rd_ext;
    alu_b         = rank_ext;
    alu_sub       = ALU_ADD;
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + node_t'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (item_r.func == FN_ADD) begin
          alu_b   = raw_ext;
          alu_sub = ALU_ADD;
          if (!key_ok) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_ADD_REJ, found_key: '0};
            state_nxt     = S_IDLE;
          end else if (item_r.delta[DELTA_W-1]) begin
            mem_req.raddr = leaf_addr;
            node_nxt      = leaf_addr;
            state_nxt     = S_LEAF;
          end else if (alu_y[ALU_W-1:COUNT_BITS] != '0) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_ADD_REJ, found_key: '0};
            state_nxt     = S_IDLE;
          end else if (item_r.delta == '0) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_OK, found_key: '0};
            state_nxt     = S_IDLE;
          end else begin
            mem_req.raddr = leaf_addr;
            node_nxt      = leaf_addr;
            state_nxt     = S_UP;
          end
        end else begin
          alu_b   = rank_ext;
          alu_sub = ALU_SUB;
          if ((item_r.rank == '0) || neg) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{status: ST_RANK_ERR, found_key: '0};
            state_nxt     = S_IDLE;
          end else begin
            rem_nxt       = rank_ext[COUNT_BITS-1:0];
            node_nxt      = ROOT_NODE;
            mem_req.raddr = node_t'(2);
            state_nxt     = S_DOWN;
          end
        end
      end
      S_LEAF: begin
        alu_b   = mag;
        alu_sub = ALU_SUB;
        if (neg) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_ADD_REJ, found_key: '0};
          state_nxt     = S_IDLE;
        end else begin
          mem_req.raddr = node_r;
          state_nxt     = S_UP;
        end
      end
      S_DOWN: begin
        alu_a   = rem_ext;
        alu_b   = rd_ext;
        alu_sub = ALU_SUB;
        if (!go_left) begin
          rem_nxt = alu_y[COUNT_BITS-1:0];
        end
        node_nxt = child;
        if (child[LEAF_BITS]) begin
          found_nxt     = KEY_W'(leaf_key);
          mem_req.raddr = child;
          state_nxt     = S_UP;
        end else begin
          mem_req.raddr = {child[NODE_W-2:0], 1'b0};
        end
      end
      S_UP: begin
        alu_a         = rd_ext;
        alu_b         = {{(ALU_W-COUNT_BITS){1'b0}}, d_step};
        alu_sub       = ALU_ADD;
        mem_req.we    = 1'b1;
        mem_req.waddr = node_r;
        mem_req.wdata = alu_y[COUNT_BITS-1:0];
        if (node_r == ROOT_NODE) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{status: ST_OK,
                            found_key: (item_r.func == FN_SEL) ? found_r : '0};
          state_nxt     = S_IDLE;
        end else begin
          mem_req.raddr = node_r >> 1;
          node_nxt      = node_r >> 1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    node_r     <= node_nxt;
    rem_r      <= rem_nxt;
    found_r    <= found_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
